// ===== rtl/core/grid_ray_caster_column_unit_defines.svh =====
// Assertion macros shared by the checker files of the column unit.
`ifndef GRID_RAY_CASTER_COLUMN_UNIT_DEFINES_SVH
`define GRID_RAY_CASTER_COLUMN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GRCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GRCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/grcc_pkg.sv =====
package grcc_pkg;

  // Fixed datapath widths, sized for the largest parameter values.
  localparam int DIV_W  = 32;
  localparam int SPAN_W = 18;
  localparam int ANG_W  = 16;
  localparam int TRIG_W = 16;
  localparam int MAG_W  = 15;

  // Angle and scaling constants.
  localparam logic [ANG_W-1:0] ANG_ZERO  = 16'd0;
  localparam logic [ANG_W-1:0] ANG_UP    = 16'd16384;
  localparam logic [ANG_W-1:0] ANG_HALF  = 16'd32768;
  localparam logic [ANG_W-1:0] ANG_DOWN  = 16'd49152;
  localparam int ONE_Q14        = 16384;
  localparam int CORDIC_START   = 39797;
  localparam int SCREEN_X_BASE  = 6;
  localparam int SCREEN_X_PITCH = 12;

  // Column angle (column * 65536 + 180) / 360, taken as (column * 8192 + 22) / 45.
  // The division by 45 is a reciprocal multiply, exact for every 7-bit column.
  localparam int ANG_COL_BIAS = 22;
  localparam int ANG_RECIP    = 1491309;
  localparam int ANG_RECIP_SH = 26;

  // Arc tangent steps of the rotation, quadrant angle scaled to 2^24 per turn.
  localparam logic [21:0] ARC_TABLE [16] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
    22'd166669,  22'd83416,   22'd41718,  22'd20860,
    22'd10430,   22'd5215,    22'd2608,   22'd1304,
    22'd652,     22'd326,     22'd163,    22'd81
  };

  // Request into the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  // Request into the shared sine and cosine unit.
  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cordic_req_t;

  // Sequencer states of the column unit.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANG_GO,
    ST_RA_GO,
    ST_RA_WAIT,
    ST_CA_GO,
    ST_CA_WAIT,
    ST_BASE,
    ST_MUL,
    ST_OFF_GO,
    ST_OFF_WAIT,
    ST_TEST,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_PICK,
    ST_CMUL,
    ST_HGT_GO,
    ST_HGT_WAIT
  } state_t;

endpackage

// ===== rtl/core/grid_ray_caster_column_unit.sv =====
// Channel   Ports                                   Transfer
// request   start, busy, in_*                       start high while busy low
// result    out_strobe, out_*                       one cycle, cannot be held off
// config    cfg_we, cfg_wdata                       written when cfg_we is high
//
// From the taken request to the result strobe a column tests up to 2 * STEP_LIMIT grid
// lines, each with an offset divide, and adds a distance divide per axis that finds a
// wall; a hit adds the height divide, which a zero distance skips.
// The 32-step shared divider does most of the work; sine and cosine come from a shared
// 16-step rotation unit, run twice per column.
// Synchronous active-low reset clears the sequencer and the wall map.
// busy is high from the request until the result strobe; no request is taken meanwhile.
module grid_ray_caster_column_unit #(
  parameter int TILE_PIXELS   = 48,
  parameter int SCREEN_HEIGHT = 720,
  parameter int STEP_LIMIT    = 8,
  parameter int MAP_SIDE      = 8,
  parameter int COLUMNS       = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_view_angle,
  input  logic [6:0]  in_column,
  output logic        out_strobe,
  output logic [9:0]  out_screen_x,
  output logic [8:0]  out_line_top,
  output logic [9:0]  out_slice_height,
  output logic        out_wall_side,
  output logic        out_hit,
  output logic [15:0] out_corrected_distance,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import grcc_pkg::*;

  localparam int TILE      = TILE_PIXELS * 128;
  localparam int BASE_MAX  = 65535 / TILE;
  localparam int MAP_EXT   = MAP_SIDE * TILE;
  localparam int HALF_ANG  = ((COLUMNS / 2) * 65536 + 180) / 360;
  localparam int HNUM      = TILE_PIXELS * SCREEN_HEIGHT * 128;
  localparam int STEP_LAST = STEP_LIMIT - 1;

  state_t state_r, state_nxt;
  logic [63:0]              wall_map_r;
  logic [15:0]              px_r, px_nxt, py_r, py_nxt, va_r, va_nxt;
  logic [6:0]               col_r, col_nxt;
  logic [ANG_W-1:0]         ra_r, ra_nxt, ca_r, ca_nxt;
  logic signed [TRIG_W-1:0] c_r, c_nxt, s_r, s_nxt;
  logic [MAG_W-1:0]         cc_r, cc_nxt;
  logic                     axis_r, axis_nxt;
  logic [SPAN_W-1:0]        span_r, span_nxt;
  logic signed [7:0]        mcell_r, mcell_nxt;
  logic [3:0]               step_r, step_nxt;
  logic [DIV_W-1:0]         prod_r, prod_nxt, off_r, off_nxt;
  logic                     hh_r, hh_nxt, vh_r, vh_nxt;
  logic [DIV_W-1:0]         hd_r, hd_nxt, vd_r, vd_nxt, dist_r, dist_nxt, d_r, d_nxt;
  logic                     side_r, side_nxt;
  logic                     strobe_r, strobe_nxt;
  logic [9:0]               sx_r, sx_nxt, hgt_r, hgt_nxt;
  logic [8:0]               top_r, top_nxt;
  logic                     oside_r, oside_nxt, ohit_r, ohit_nxt;
  logic [15:0]              ocd_r, ocd_nxt;

  div_req_t    div_req;
  cordic_req_t cor_req;
  logic             div_done, cor_done;
  logic [DIV_W-1:0] div_quo;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;

  // Per-axis march operands.
  logic [15:0]      pm, pc;
  logic [MAG_W-1:0] abs_c, abs_s, dm, dc;
  logic             c_pos, s_pos, fwd, cneg, skip;
  logic [4:0]       base_v;
  logic [16:0]      base_t;
  logic signed [33:0] cpos;
  logic [2:0]       ccell, row, colc;
  logic [5:0]       bit_idx;
  logic             in_map, wall;
  logic [46:0]      cmul;
  logic [41:0]      ang_prod;
  logic [ANG_W-1:0] col_ang;
  logic [9:0]       fin_h;
  logic             fin_en, fin_hit;

  grcc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  grcc_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cor_req),
    .done (cor_done),
    .cos_q(cor_cos),
    .sin_q(cor_sin)
  );

  // Column angle offset by reciprocal multiplication.
  assign ang_prod = 42'({col_r, 13'd0} + 20'(ANG_COL_BIAS)) * 42'(ANG_RECIP);
  assign col_ang  = ang_prod[ANG_RECIP_SH +: ANG_W];

  // Direction and magnitude of the ray components.
  assign abs_c = c_r[TRIG_W-1] ? MAG_W'(-c_r) : c_r[MAG_W-1:0];
  assign abs_s = s_r[TRIG_W-1] ? MAG_W'(-s_r) : s_r[MAG_W-1:0];
  assign c_pos = !c_r[TRIG_W-1] && (c_r != '0);
  assign s_pos = !s_r[TRIG_W-1] && (s_r != '0);

  // Horizontal lines march along y, vertical lines along x.
  assign pm   = axis_r ? px_r : py_r;
  assign pc   = axis_r ? py_r : px_r;
  assign dm   = axis_r ? abs_c : abs_s;
  assign dc   = axis_r ? abs_s : abs_c;
  assign fwd  = axis_r ? c_pos : s_pos;
  assign cneg = axis_r ? s_r[TRIG_W-1] : c_r[TRIG_W-1];
  assign skip = axis_r ? (ra_r == ANG_UP || ra_r == ANG_DOWN || c_r == '0)
                       : (ra_r == ANG_ZERO || ra_r == ANG_HALF || s_r == '0);

  // Tile index of the viewer along the main axis.
  always_comb begin
    base_v = '0;
    base_t = '0;
    for (int k = 1; k <= BASE_MAX; k++) begin
      if ({1'b0, pm} >= 17'(k * TILE)) begin
        base_v = 5'(k);
        base_t = 17'(k * TILE);
      end
    end
  end

  // Crossing point on the current line and its map tile.
  assign cpos = cneg ? signed'({18'd0, pc}) - signed'({2'b00, off_r})
                     : signed'({18'd0, pc}) + signed'({2'b00, off_r});
  assign in_map = !cpos[33] && (cpos < 34'(MAP_EXT)) &&
                  !mcell_r[7] && (mcell_r < 8'(MAP_SIDE));

  always_comb begin
    ccell = '0;
    for (int k = 1; k < MAP_SIDE; k++) begin
      if (cpos[16:0] >= 17'(k * TILE)) ccell = 3'(k);
    end
  end

  assign row     = axis_r ? ccell : mcell_r[2:0];
  assign colc    = axis_r ? mcell_r[2:0] : ccell;
  assign bit_idx = 6'(row * 6'(MAP_SIDE)) + 6'(colc);
  assign wall    = in_map && wall_map_r[bit_idx];
  assign cmul    = 47'(dist_r) * 47'(cc_r);

  // Shared divider operands by sequencer state.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      ST_OFF_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r;
        div_req.den   = DIV_W'(dm);
      end
      ST_DIST_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(span_r) << 14;
        div_req.den   = DIV_W'(dm);
      end
      ST_HGT_GO: begin
        div_req.start = (d_r != '0);
        div_req.num   = DIV_W'(HNUM);
        div_req.den   = d_r;
      end
      default: div_req = '0;
    endcase
  end

  // Shared rotation unit operands.
  assign cor_req = {(state_r == ST_RA_GO) || (state_r == ST_CA_GO),
                    (state_r == ST_RA_GO) ? ra_r : ca_r};

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt  = state_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    va_nxt     = va_r;
    col_nxt    = col_r;
    ra_nxt     = ra_r;
    ca_nxt     = ca_r;
    c_nxt      = c_r;
    s_nxt      = s_r;
    cc_nxt     = cc_r;
    axis_nxt   = axis_r;
    span_nxt   = span_r;
    mcell_nxt  = mcell_r;
    step_nxt   = step_r;
    prod_nxt   = prod_r;
    off_nxt    = off_r;
    hh_nxt     = hh_r;
    vh_nxt     = vh_r;
    hd_nxt     = hd_r;
    vd_nxt     = vd_r;
    dist_nxt   = dist_r;
    side_nxt   = side_r;
    d_nxt      = d_r;
    strobe_nxt = 1'b0;
    sx_nxt     = sx_r;
    hgt_nxt    = hgt_r;
    top_nxt    = top_r;
    oside_nxt  = oside_r;
    ohit_nxt   = ohit_r;
    ocd_nxt    = ocd_r;
    fin_en     = 1'b0;
    fin_hit    = 1'b0;
    fin_h      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          va_nxt    = in_view_angle;
          col_nxt   = in_column;
          state_nxt = ST_ANG_GO;
        end
      end
      ST_ANG_GO: begin
        ra_nxt    = va_r + col_ang - ANG_W'(HALF_ANG);
        ca_nxt    = ANG_W'(HALF_ANG) - col_ang;
        state_nxt = ST_RA_GO;
      end
      ST_RA_GO: state_nxt = ST_RA_WAIT;
      ST_RA_WAIT: begin
        if (cor_done) begin
          c_nxt     = cor_cos;
          s_nxt     = cor_sin;
          state_nxt = ST_CA_GO;
        end
      end
      ST_CA_GO: state_nxt = ST_CA_WAIT;
      ST_CA_WAIT: begin
        if (cor_done) begin
          cc_nxt    = cor_cos[TRIG_W-1] ? '0 : cor_cos[MAG_W-1:0];
          axis_nxt  = 1'b0;
          hh_nxt    = 1'b0;
          vh_nxt    = 1'b0;
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        // First crossed line of this axis, or skip an axis-parallel ray.
        step_nxt = '0;
        if (fwd) begin
          span_nxt  = 18'(base_t) + 18'(TILE) - 18'(pm);
          mcell_nxt = signed'(8'(base_v)) + 8'sd1;
        end else begin
          span_nxt  = 18'(pm) - 18'(base_t);
          mcell_nxt = signed'(8'(base_v)) - 8'sd1;
        end
        if (skip) begin
          if (!axis_r) axis_nxt = 1'b1;
          state_nxt = axis_r ? ST_PICK : ST_BASE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = 32'(33'(span_r) * 33'(dc));
        state_nxt = ST_OFF_GO;
      end
      ST_OFF_GO: state_nxt = ST_OFF_WAIT;
      ST_OFF_WAIT: begin
        if (div_done) begin
          off_nxt   = div_quo;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        // Wall test, then the next line or the other axis.
        if (wall) begin
          state_nxt = ST_DIST_GO;
        end else if (step_r == 4'(STEP_LAST)) begin
          if (!axis_r) axis_nxt = 1'b1;
          state_nxt = axis_r ? ST_PICK : ST_BASE;
        end else begin
          step_nxt  = step_r + 4'd1;
          span_nxt  = span_r + 18'(TILE);
          mcell_nxt = fwd ? mcell_r + 8'sd1 : mcell_r - 8'sd1;
          state_nxt = ST_MUL;
        end
      end
      ST_DIST_GO: state_nxt = ST_DIST_WAIT;
      ST_DIST_WAIT: begin
        if (div_done) begin
          if (axis_r) begin
            vh_nxt    = 1'b1;
            vd_nxt    = div_quo;
            state_nxt = ST_PICK;
          end else begin
            hh_nxt    = 1'b1;
            hd_nxt    = div_quo;
            axis_nxt  = 1'b1;
            state_nxt = ST_BASE;
          end
        end
      end
      ST_PICK: begin
        // A tie goes to the horizontal hit.
        if (hh_r && (!vh_r || hd_r <= vd_r)) begin
          dist_nxt  = hd_r;
          side_nxt  = 1'b0;
          state_nxt = ST_CMUL;
        end else if (vh_r) begin
          dist_nxt  = vd_r;
          side_nxt  = 1'b1;
          state_nxt = ST_CMUL;
        end else begin
          side_nxt  = 1'b0;
          fin_en    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CMUL: begin
        d_nxt     = cmul[45:14];
        state_nxt = ST_HGT_GO;
      end
      ST_HGT_GO: begin
        if (d_r == '0) begin
          fin_en    = 1'b1;
          fin_hit   = 1'b1;
          fin_h     = 10'(SCREEN_HEIGHT);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HGT_WAIT;
        end
      end
      ST_HGT_WAIT: begin
        if (div_done) begin
          fin_en    = 1'b1;
          fin_hit   = 1'b1;
          fin_h     = (div_quo > DIV_W'(SCREEN_HEIGHT)) ? 10'(SCREEN_HEIGHT)
                                                        : div_quo[9:0];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Result register load.
    if (fin_en) begin
      strobe_nxt = 1'b1;
      sx_nxt     = 10'(11'(SCREEN_X_BASE) + 11'(col_r) * 11'(SCREEN_X_PITCH));
      hgt_nxt    = fin_h;
      top_nxt    = 9'((11'(SCREEN_HEIGHT) - 11'(fin_h)) >> 1);
      oside_nxt  = fin_hit ? side_r : 1'b0;
      ohit_nxt   = fin_hit;
      if (!fin_hit || d_r[31:1] > 31'd65535) ocd_nxt = 16'hFFFF;
      else                                    ocd_nxt = d_r[16:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      strobe_r   <= 1'b0;
      wall_map_r <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) wall_map_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    va_r    <= va_nxt;
    col_r   <= col_nxt;
    ra_r    <= ra_nxt;
    ca_r    <= ca_nxt;
    c_r     <= c_nxt;
    s_r     <= s_nxt;
    cc_r    <= cc_nxt;
    axis_r  <= axis_nxt;
    span_r  <= span_nxt;
    mcell_r <= mcell_nxt;
    step_r  <= step_nxt;
    prod_r  <= prod_nxt;
    off_r   <= off_nxt;
    hh_r    <= hh_nxt;
    vh_r    <= vh_nxt;
    hd_r    <= hd_nxt;
    vd_r    <= vd_nxt;
    dist_r  <= dist_nxt;
    side_r  <= side_nxt;
    d_r     <= d_nxt;
    sx_r    <= sx_nxt;
    hgt_r   <= hgt_nxt;
    top_r   <= top_nxt;
    oside_r <= oside_nxt;
    ohit_r  <= ohit_nxt;
    ocd_r   <= ocd_nxt;
  end

  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = strobe_r;
  assign out_screen_x           = sx_r;
  assign out_line_top           = top_r;
  assign out_slice_height       = hgt_r;
  assign out_wall_side          = oside_r;
  assign out_hit                = ohit_r;
  assign out_corrected_distance = ocd_r;

endmodule

// ===== rtl/core/grcc_cordic.sv =====
module grcc_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  grcc_pkg::cordic_req_t         req,
  output logic                          done,
  output logic signed [grcc_pkg::TRIG_W-1:0] cos_q,
  output logic signed [grcc_pkg::TRIG_W-1:0] sin_q
);
  import grcc_pkg::*;

  logic signed [19:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [23:0] z_r, z_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic               run_r, run_nxt, done_r, done_nxt;
  logic signed [19:0] dx, dy;
  logic signed [23:0] arc;
  logic [MAG_W-1:0]   cq, sq;

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [19:0] tz_shr(input logic signed [19:0] v,
                                                input logic [3:0] sh);
    logic [19:0] mag;
    mag = v[19] ? 20'(-v) : 20'(v);
    mag = mag >> sh;
    return v[19] ? -signed'(mag) : signed'(mag);
  endfunction

  // Drop two fraction bits and clamp to the range 0 to one.
  function automatic logic [MAG_W-1:0] clamp_q14(input logic signed [19:0] v);
    logic signed [19:0] t;
    t = tz_shr(v, 4'd2);
    if (t[19]) return '0;
    if (t > 20'(ONE_Q14)) return MAG_W'(ONE_Q14);
    return t[MAG_W-1:0];
  endfunction

  assign dx  = tz_shr(y_r, cnt_r);
  assign dy  = tz_shr(x_r, cnt_r);
  assign arc = signed'({2'b00, ARC_TABLE[cnt_r]});

  // One rotation step per cycle.
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    quad_nxt = quad_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      x_nxt    = 20'(CORDIC_START);
      y_nxt    = '0;
      z_nxt    = signed'({2'b00, req.angle[13:0], 8'h00});
      quad_nxt = req.angle[15:14];
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!z_r[23]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - arc;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + arc;
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    quad_r <= quad_nxt;
  end

  // Fold the first quadrant result back to the full circle.
  assign cq = clamp_q14(x_r);
  assign sq = clamp_q14(y_r);

  always_comb begin
    unique case (quad_r)
      2'd0: begin
        cos_q = signed'({1'b0, cq});
        sin_q = signed'({1'b0, sq});
      end
      2'd1: begin
        cos_q = -signed'({1'b0, sq});
        sin_q = signed'({1'b0, cq});
      end
      2'd2: begin
        cos_q = -signed'({1'b0, cq});
        sin_q = -signed'({1'b0, sq});
      end
      default: begin
        cos_q = signed'({1'b0, sq});
        sin_q = -signed'({1'b0, cq});
      end
    endcase
  end

  assign done = done_r;

endmodule

// ===== rtl/core/grcc_div.sv =====
module grcc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  grcc_pkg::div_req_t         req,
  output logic                       done,
  output logic [grcc_pkg::DIV_W-1:0] quo
);
  import grcc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? DIV_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/grcc_checker.sv =====
`include "grid_ray_caster_column_unit_defines.svh"

module grcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [9:0]  out_slice_height,
  input logic        out_wall_side,
  input logic        out_hit,
  input logic [15:0] out_corrected_distance
);

  // A taken request keeps the unit busy in the next cycle.
  `GRCC_ASSERT_NXT(a_req_busy, clk, rst_n, start && !busy, busy, "request not taken")

  // A result is shown for one cycle only.
  `GRCC_ASSERT_NXT(a_one_pulse, clk, rst_n, out_strobe, !out_strobe, "result repeated")

  // A result ends the work of a request.
  `GRCC_ASSERT_IMP(a_end_work, clk, rst_n, out_strobe, !busy && $past(busy), "result without a request")

  // A miss reports an empty slice and the far distance.
  `GRCC_ASSERT_IMP(a_miss, clk, rst_n, out_strobe && !out_hit, out_slice_height == 10'd0 && !out_wall_side && out_corrected_distance == 16'hFFFF, "bad miss result")

endmodule

bind grid_ray_caster_column_unit grcc_checker u_grcc_checker (.*);
